### hdl/ffra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types, widths and codes of the first-fit run allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int DEF_HEAP_SIZE = 64;
    localparam int DEF_MAX_HEAPS = 8;

    localparam int KIND_W = 2;
    localparam int LEN_W  = 7;
    localparam int SEL_W  = 3;
    localparam int SLOT_W = 6;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_BAD_COUNT = 2'd2,
        ST_BAD_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic map_we;
        logic tag_we;
    } t_bank_wr;

endpackage

### hdl/ffra_run_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_run_finder
// Finds the lowest start of a run of free slots of the requested length in
// one heap bitmap, by doubling runs of length 2^k and folding in each set
// bit of the length.
// ----------------------------------------------------------------------------
module ffra_run_finder
    import ffra_pkg::*;
#(
    parameter int HEAP_SIZE = DEF_HEAP_SIZE
) (
    input  logic [HEAP_SIZE-1:0] i_map,
    input  logic [LEN_W-1:0]     i_len,
    output logic                 o_found,
    output logic [SLOT_W-1:0]    o_at
);

    localparam int W = HEAP_SIZE + 1;

    logic [W-1:0] w_fit;

    always_comb begin
        logic [W-1:0] pw;
        logic [W-1:0] rr;
        pw = {1'b0, i_map};
        rr = '1;
        for (int k = 0; k < LEN_W; k++) begin
            if (i_len[k]) begin
                rr = pw & (rr >> (1 << k));
            end
            pw = pw & (pw >> (1 << k));
        end
        w_fit = rr;
    end

    always_comb begin
        o_found = |w_fit[HEAP_SIZE-1:0];
        o_at    = '0;
        for (int p = HEAP_SIZE - 1; p >= 0; p--) begin
            if (w_fit[p]) begin
                o_at = SLOT_W'(p);
            end
        end
    end

endmodule

### hdl/ffra_heap_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_heap_bank
// Per-heap free bitmaps and kind tags with one read and one write port.
// Entries are written when a heap opens before they are ever read.
// ----------------------------------------------------------------------------
module ffra_heap_bank
    import ffra_pkg::*;
#(
    parameter int HEAP_SIZE = DEF_HEAP_SIZE,
    parameter int MAX_HEAPS = DEF_MAX_HEAPS,
    parameter int HIW       = (MAX_HEAPS > 1) ? $clog2(MAX_HEAPS) : 1
) (
    input  logic                 i_clk,
    input  logic [HIW-1:0]       i_rd_idx,
    output logic [HEAP_SIZE-1:0] o_rd_map,
    output logic [KIND_W-1:0]    o_rd_tag,
    input  t_bank_wr             i_wr,
    input  logic [HIW-1:0]       i_wr_idx,
    input  logic [HEAP_SIZE-1:0] i_wr_map,
    input  logic [KIND_W-1:0]    i_wr_tag
);

    logic [HEAP_SIZE-1:0] r_map [MAX_HEAPS];
    logic [KIND_W-1:0]    r_tag [MAX_HEAPS];

    always_ff @(posedge i_clk) begin
        if (i_wr.map_we) begin
            r_map[i_wr_idx] <= i_wr_map;
        end
        if (i_wr.tag_we) begin
            r_tag[i_wr_idx] <= i_wr_tag;
        end
    end

    assign o_rd_map = r_map[i_rd_idx];
    assign o_rd_tag = r_tag[i_rd_idx];

endmodule

### hdl/first_fit_run_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_run_allocator
// Allocates and frees runs of contiguous slots across a set of heaps.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the request fields and raise start; the transaction is taken at a
//   clock edge where start is high and busy is low. Busy stays high until the
//   result strobe o_done (rejects never raise busy), which marks o_status,
//   o_heap_index and o_slot_offset for exactly one cycle. The receiver
//   cannot stall; a new request may be issued in the cycle of the strobe.
//   Steps from the accepting edge to the strobe:
//     rejected request (bad count or range): strobe straight from idle
//     free: through the write state
//     allocate hitting heap j (scan order): scan heaps 0 to j, then write
//     allocate opening a new heap: scan all open heaps, then open and write
//     allocate with no heap left: scan all heaps, then strobe no space
//   The scan examines one opened heap per cycle through a single run finder.
//   Reset (synchronous, active low) closes all heaps and drops any request in
//   flight; heap contents are rebuilt when a heap opens.
// ----------------------------------------------------------------------------
module first_fit_run_allocator
    import ffra_pkg::*;
#(
    parameter int HEAP_SIZE = DEF_HEAP_SIZE,
    parameter int MAX_HEAPS = DEF_MAX_HEAPS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_req_type,
    input  logic [KIND_W-1:0] i_heap_kind,
    input  logic [LEN_W-1:0]  i_run_length,
    input  logic [SEL_W-1:0]  i_heap_select,
    input  logic [SLOT_W-1:0] i_start_slot,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [SEL_W-1:0]  o_heap_index,
    output logic [SLOT_W-1:0] o_slot_offset
);

    localparam int CW  = $clog2(MAX_HEAPS + 1);
    localparam int HIW = (MAX_HEAPS > 1) ? $clog2(MAX_HEAPS) : 1;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_open, n_open;
    logic [CW-1:0]       r_h, n_h;
    logic                r_free, n_free;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [SLOT_W-1:0]   r_first, n_first;
    logic                r_fresh, n_fresh;
    logic                r_done, n_done;
    t_status             r_status, n_status;
    logic [SEL_W-1:0]    r_hidx, n_hidx;
    logic [SLOT_W-1:0]   r_off, n_off;

    logic [HEAP_SIZE-1:0] w_rd_map;
    logic [KIND_W-1:0]    w_rd_tag;
    logic [HEAP_SIZE-1:0] w_wr_map;
    logic [HEAP_SIZE-1:0] w_mask;
    t_bank_wr             w_wr;
    logic                 w_found;
    logic [SLOT_W-1:0]    w_at;
    logic                 w_len_bad;
    logic                 w_sel_bad;
    logic                 w_range_bad;

    ffra_heap_bank #(
        .HEAP_SIZE(HEAP_SIZE),
        .MAX_HEAPS(MAX_HEAPS),
        .HIW      (HIW)
    ) u_bank (
        .i_clk   (i_clk),
        .i_rd_idx(r_h[HIW-1:0]),
        .o_rd_map(w_rd_map),
        .o_rd_tag(w_rd_tag),
        .i_wr    (w_wr),
        .i_wr_idx(r_h[HIW-1:0]),
        .i_wr_map(w_wr_map),
        .i_wr_tag(r_kind)
    );

    ffra_run_finder #(
        .HEAP_SIZE(HEAP_SIZE)
    ) u_finder (
        .i_map  (w_rd_map),
        .i_len  (r_len),
        .o_found(w_found),
        .o_at   (w_at)
    );

    assign w_len_bad   = (i_run_length == '0) || (i_run_length > LEN_W'(HEAP_SIZE));
    assign w_sel_bad   = (int'(i_heap_select) >= int'(r_open));
    assign w_range_bad = ({2'b00, i_start_slot} + {1'b0, i_run_length}) > 8'(HEAP_SIZE);

    always_comb begin
        for (int p = 0; p < HEAP_SIZE; p++) begin
            w_mask[p] = (p >= int'(r_first)) && (p < int'(r_first) + int'(r_len));
        end
    end

    always_comb begin
        if (r_free) begin
            w_wr_map = w_rd_map | w_mask;
        end else if (r_fresh) begin
            w_wr_map = ~w_mask;
        end else begin
            w_wr_map = w_rd_map & ~w_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_open  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h      <= n_h;
        r_free   <= n_free;
        r_kind   <= n_kind;
        r_len    <= n_len;
        r_first  <= n_first;
        r_fresh  <= n_fresh;
        r_status <= n_status;
        r_hidx   <= n_hidx;
        r_off    <= n_off;
    end

    always_comb begin
        n_state  = r_state;
        n_open   = r_open;
        n_h      = r_h;
        n_free   = r_free;
        n_kind   = r_kind;
        n_len    = r_len;
        n_first  = r_first;
        n_fresh  = r_fresh;
        n_done   = 1'b0;
        n_status = r_status;
        n_hidx   = r_hidx;
        n_off    = r_off;
        w_wr     = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_free   = i_req_type;
                    n_kind   = i_heap_kind;
                    n_len    = i_run_length;
                    n_first  = i_start_slot;
                    n_fresh  = 1'b0;
                    n_hidx   = '0;
                    n_off    = '0;
                    n_status = ST_OK;
                    if (!i_req_type) begin
                        n_h = '0;
                        if (w_len_bad) begin
                            n_status = ST_BAD_COUNT;
                            n_done   = 1'b1;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_h = CW'(i_heap_select);
                        if (w_sel_bad) begin
                            n_status = ST_BAD_RANGE;
                            n_done   = 1'b1;
                        end else if (w_len_bad) begin
                            n_status = ST_BAD_COUNT;
                            n_done   = 1'b1;
                        end else if (w_range_bad) begin
                            n_status = ST_BAD_RANGE;
                            n_done   = 1'b1;
                        end else begin
                            n_state = S_WRITE;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_h < r_open) begin
                    if ((w_rd_tag == r_kind) && w_found) begin
                        n_first = w_at;
                        n_state = S_WRITE;
                    end else begin
                        n_h = r_h + 1'b1;
                    end
                end else if (r_open < CW'(MAX_HEAPS)) begin
                    n_h     = r_open;
                    n_open  = r_open + 1'b1;
                    n_fresh = 1'b1;
                    n_first = '0;
                    n_state = S_WRITE;
                end else begin
                    n_status = ST_NO_SPACE;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_WRITE: begin
                w_wr.map_we = 1'b1;
                w_wr.tag_we = r_fresh;
                n_status    = ST_OK;
                n_done      = 1'b1;
                if (!r_free) begin
                    n_hidx = SEL_W'(r_h);
                    n_off  = r_first;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_heap_index  = r_hidx;
    assign o_slot_offset = r_off;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type && !w_sel_bad && !w_len_bad && !w_range_bad)
            |=> busy)
        else $error("free transaction did not hold busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while still busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && $past(busy) |=> !o_done || $past(start))
        else $error("result strobe held without a new transaction");

    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= CW'(MAX_HEAPS))
        else $error("open heap count exceeds heap limit");

    a_open_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_open != $past(r_open)) |-> (r_open == $past(r_open) + 1'b1) && r_fresh)
        else $error("open heap count moved other than by one on open");

endmodule

### sim/first_fit_run_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_run_allocator_test
// Self-checking bench for the first-fit run allocator. A table of directed
// transactions covers the error statuses, heap opening, heap exhaustion and
// double free. A long random run of allocate and free transactions follows,
// including frees of runs that are still held. Every result is checked field
// by field against the table's outcome or an in-bench model of the heaps,
// with random gaps between requests.
// ----------------------------------------------------------------------------
module first_fit_run_allocator_test;
    import ffra_pkg::*;

    localparam int HEAP_SIZE    = DEF_HEAP_SIZE;
    localparam int MAX_HEAPS    = DEF_MAX_HEAPS;
    localparam int RANDOM_ITEMS = 1125;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  len;
        logic [SEL_W-1:0]  sel;
        logic [SLOT_W-1:0] slot;
    } t_request;

    typedef struct packed {
        t_status           status;
        logic [SEL_W-1:0]  heap;
        logic [SLOT_W-1:0] offset;
    } t_outcome;

    typedef struct packed {
        t_request req;
        logic     typed;
        t_outcome outcome;
    } t_row;

    typedef struct packed {
        logic [SEL_W-1:0]  heap;
        logic [SLOT_W-1:0] first;
        logic [LEN_W-1:0]  len;
    } t_held_run;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_req_type;
    logic [KIND_W-1:0] i_heap_kind;
    logic [LEN_W-1:0]  i_run_length;
    logic [SEL_W-1:0]  i_heap_select;
    logic [SLOT_W-1:0] i_start_slot;
    logic              o_done;
    logic [1:0]        o_status;
    logic [SEL_W-1:0]  o_heap_index;
    logic [SLOT_W-1:0] o_slot_offset;

    int                open_count;
    logic [KIND_W-1:0] heap_tag [MAX_HEAPS];
    logic [63:0]       heap_map [MAX_HEAPS];
    int                heap_free [MAX_HEAPS];

    t_outcome  pending_outcomes[$];
    t_held_run held_runs[$];
    t_row      directed_rows[$];
    int        error_count = 0;
    int        cycle_count = 0;
    logic      burst_mode  = 1'b0;

    first_fit_run_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_heap_kind   (i_heap_kind),
        .i_run_length  (i_run_length),
        .i_heap_select (i_heap_select),
        .i_start_slot  (i_start_slot),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_heap_index  (o_heap_index),
        .o_slot_offset (o_slot_offset)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int first_free_run(input logic [63:0] map, input int len);
        int first;
        int run;
        first = 0;
        run = 0;
        for (int pos = 0; pos < HEAP_SIZE; pos++) begin
            if (!map[pos]) begin
                run = 0;
            end else begin
                if (run == 0) first = pos;
                run++;
                if (run >= len) return first;
            end
        end
        return -1;
    endfunction

    function automatic logic [63:0] slot_mask(input int first, input int len);
        logic [127:0] wide;
        wide = ((128'd1 << len) - 128'd1) << first;
        return wide[63:0];
    endfunction

    function automatic t_outcome predict_outcome(input t_request r);
        t_outcome    res;
        int          len;
        int          hit;
        int          at;
        logic [63:0] mask;
        res = '{status: ST_OK, heap: '0, offset: '0};
        len = int'(r.len);
        if (r.req_type == REQ_ALLOC) begin
            if (len == 0 || len > HEAP_SIZE) begin
                res.status = ST_BAD_COUNT;
            end else begin
                hit = -1;
                at = -1;
                for (int h = 0; h < open_count; h++) begin
                    if (heap_tag[h] == r.kind && heap_free[h] >= len) begin
                        at = first_free_run(heap_map[h], len);
                        if (at >= 0) begin
                            hit = h;
                            break;
                        end
                    end
                end
                if (hit < 0 && open_count < MAX_HEAPS) begin
                    hit = open_count;
                    open_count++;
                    heap_tag[hit] = r.kind;
                    heap_map[hit] = slot_mask(0, HEAP_SIZE);
                    heap_free[hit] = HEAP_SIZE;
                    at = 0;
                end
                if (hit < 0) begin
                    res.status = ST_NO_SPACE;
                end else begin
                    heap_map[hit] &= ~slot_mask(at, len);
                    heap_free[hit] -= len;
                    res.heap = SEL_W'(hit);
                    res.offset = SLOT_W'(at);
                end
            end
        end else begin
            if (int'(r.sel) >= open_count) begin
                res.status = ST_BAD_RANGE;
            end else if (len == 0 || len > HEAP_SIZE) begin
                res.status = ST_BAD_COUNT;
            end else if (int'(r.slot) + len > HEAP_SIZE) begin
                res.status = ST_BAD_RANGE;
            end else begin
                mask = slot_mask(int'(r.slot), len);
                heap_free[r.sel] += $countones(mask & ~heap_map[r.sel]);
                heap_map[r.sel] |= mask;
            end
        end
        return res;
    endfunction

    task automatic issue(input t_request r, input logic typed, input t_outcome given);
        t_outcome predicted;
        i_req_type    <= r.req_type;
        i_heap_kind   <= r.kind;
        i_run_length  <= r.len;
        i_heap_select <= r.sel;
        i_start_slot  <= r.slot;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        predicted = predict_outcome(r);
        pending_outcomes.push_back(typed ? given : predicted);
        if (r.req_type == REQ_ALLOC && predicted.status == ST_OK) begin
            held_runs.push_back('{heap: predicted.heap, first: predicted.offset, len: r.len});
        end
    endtask

    task automatic hold_off();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (burst_mode || pick < 55) begin
            gap = 0;
        end else if (pick < 90) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(10, 40);
        end
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        if (pending_outcomes.size() != 0) begin
            start <= 1'b0;
            while (pending_outcomes.size() != 0) @(posedge i_clk);
        end
    endtask

    function automatic t_request pick_request();
        t_request  r;
        t_held_run run;
        int        pick;
        int        idx;
        r.req_type = REQ_ALLOC;
        r.kind = KIND_W'($urandom_range(0, 3));
        r.sel  = SEL_W'($urandom_range(0, 7));
        r.slot = SLOT_W'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (pick >= 85) begin
            r.req_type = 1'($urandom_range(0, 1));
            r.len = LEN_W'($urandom_range(0, 127));
        end else if (pick >= 45 && held_runs.size() != 0) begin
            idx = $urandom_range(0, held_runs.size() - 1);
            run = held_runs[idx];
            held_runs.delete(idx);
            r.req_type = REQ_FREE;
            r.sel = run.heap;
            r.slot = run.first;
            r.len = run.len;
            if ($urandom_range(0, 9) == 0) begin
                r.len = LEN_W'($urandom_range(1, int'(run.len)));
            end
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                r.len = LEN_W'($urandom_range(1, 12));
            end else if (pick < 95) begin
                r.len = LEN_W'($urandom_range(13, HEAP_SIZE));
            end else if (pick < 97) begin
                r.len = '0;
            end else begin
                r.len = LEN_W'($urandom_range(HEAP_SIZE + 1, 127));
            end
        end
        return r;
    endfunction

    function automatic void add_row(
        input logic req_type, input int kind, input int len, input int sel,
        input int slot, input logic typed, input t_status status,
        input int heap, input int offset);
        t_row row;
        row.req = '{req_type: req_type, kind: KIND_W'(kind), len: LEN_W'(len),
                    sel: SEL_W'(sel), slot: SLOT_W'(slot)};
        row.typed = typed;
        row.outcome = '{status: status, heap: SEL_W'(heap), offset: SLOT_W'(offset)};
        directed_rows.push_back(row);
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (pending_outcomes.size() == 0) begin
                flag_mismatch($sformatf("result with nothing outstanding, status %0d",
                                        o_status));
            end else begin
                want = pending_outcomes.pop_front();
                if (o_status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_heap_index !== want.heap)
                    flag_mismatch($sformatf("heap_index %0d, want %0d",
                                            o_heap_index, want.heap));
                if (o_slot_offset !== want.offset)
                    flag_mismatch($sformatf("slot_offset %0d, want %0d",
                                            o_slot_offset, want.offset));
            end
        end
    end

    initial begin
        t_request r;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_req_type    <= REQ_ALLOC;
        i_heap_kind   <= '0;
        i_run_length  <= '0;
        i_heap_select <= '0;
        i_start_slot  <= '0;
        open_count = 0;
        for (int h = 0; h < MAX_HEAPS; h++) begin
            heap_tag[h] = '0;
            heap_map[h] = slot_mask(0, HEAP_SIZE);
            heap_free[h] = HEAP_SIZE;
        end

        add_row(REQ_FREE,  0,   1, 0,  0, 1'b1, ST_BAD_RANGE, 0, 0);
        add_row(REQ_ALLOC, 0,   0, 0,  0, 1'b1, ST_BAD_COUNT, 0, 0);
        add_row(REQ_ALLOC, 1,  65, 0,  0, 1'b1, ST_BAD_COUNT, 0, 0);
        add_row(REQ_ALLOC, 2, 127, 7, 63, 1'b1, ST_BAD_COUNT, 0, 0);
        add_row(REQ_ALLOC, 0,  64, 0,  0, 1'b1, ST_OK,        0, 0);
        add_row(REQ_ALLOC, 0,   1, 0,  0, 1'b1, ST_OK,        1, 0);
        add_row(REQ_ALLOC, 3,  64, 0,  0, 1'b1, ST_OK,        2, 0);
        add_row(REQ_FREE,  0,   0, 1,  0, 1'b1, ST_BAD_COUNT, 0, 0);
        add_row(REQ_FREE,  0,   2, 1, 63, 1'b1, ST_BAD_RANGE, 0, 0);
        add_row(REQ_FREE,  0,  64, 0,  0, 1'b1, ST_OK,        0, 0);
        add_row(REQ_FREE,  0,  64, 0,  0, 1'b1, ST_OK,        0, 0);
        add_row(REQ_FREE,  0,   1, 5,  0, 1'b1, ST_BAD_RANGE, 0, 0);
        add_row(REQ_ALLOC, 0,  64, 0,  0, 1'b0, ST_OK,        0, 0);
        add_row(REQ_FREE,  3,   8, 0,  8, 1'b0, ST_OK,        0, 0);
        add_row(REQ_ALLOC, 0,   4, 0,  0, 1'b0, ST_OK,        0, 0);
        add_row(REQ_ALLOC, 0,   5, 0,  0, 1'b0, ST_OK,        0, 0);
        add_row(REQ_ALLOC, 1,  64, 0,  0, 1'b0, ST_OK,        0, 0);
        add_row(REQ_ALLOC, 2,  64, 0,  0, 1'b0, ST_OK,        0, 0);
        add_row(REQ_ALLOC, 1,  64, 0,  0, 1'b0, ST_OK,        0, 0);
        add_row(REQ_ALLOC, 2,  64, 0,  0, 1'b0, ST_OK,        0, 0);
        add_row(REQ_ALLOC, 3,  64, 0,  0, 1'b0, ST_OK,        0, 0);
        add_row(REQ_ALLOC, 1,  64, 0,  0, 1'b1, ST_NO_SPACE,  0, 0);
        add_row(REQ_FREE,  0,  64, 7, 63, 1'b1, ST_BAD_RANGE, 0, 0);
        add_row(REQ_FREE,  0,   1, 7, 63, 1'b0, ST_OK,        0, 0);
        add_row(REQ_ALLOC, 3,   1, 0,  0, 1'b0, ST_OK,        0, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].outcome);
            hold_off();
        end
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 2) wait_drained();
            r = pick_request();
            issue(r, 1'b0, '0);
            hold_off();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
